### rtl/dbd_pkg.sv
// package for the detection box decoder
// holds transaction structs, controller states, command struct, register indexes and helpers
// no dependencies
package dbd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_BASE = 3'd2;

	localparam logic [12:0] RST_SCORE_MIN = 13'd1024;
	localparam logic [12:0] RST_GRID_STEP = 13'd128;
	localparam logic [14:0] RST_ANCHOR    = 15'd4096;

	localparam logic [14:0] SIZE_MAX = 15'h7fff;
	localparam logic signed [17:0] Q_ONE_EDGE = 18'sd4096;
	localparam logic [12:0] Q_ONE = 13'd4096;

	typedef struct packed {
		logic signed [15:0] raw_w;
		logic signed [15:0] raw_h;
		logic signed [15:0] raw_cx;
		logic signed [15:0] raw_cy;
		logic signed [15:0] objectness;
		logic signed [15:0] class_score;
		logic [7:0]         cell_col;
		logic [7:0]         cell_row;
		logic [1:0]         anchor_index;
		logic               last_class;
	} in_item_t;

	typedef struct packed {
		logic        kept;
		logic [14:0] probability;
		logic [6:0]  label;
		logic [12:0] center_x;
		logic [12:0] center_y;
		logic [12:0] width;
		logic [12:0] height;
	} out_item_t;

	typedef struct packed {
		logic [12:0] score_min;
		logic [12:0] grid_step;
		logic [14:0] anchor_w;
		logic [14:0] anchor_h;
	} cfg_view_t;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_SQUARE,
		ST_SCALE,
		ST_BOUNDS,
		ST_FINISH
	} dbd_state_t;

	typedef struct packed {
		logic sample;
		logic accum;
		logic square;
		logic scale;
		logic bounds;
		logic load_out;
	} dbd_cmd_t;

	function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
		logic signed [15:0] r;
		if (v > 22'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -22'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

### rtl/dbd_cfg.sv
// configuration registers of the detection box decoder and anchor selection
// depends on dbd_pkg
module dbd_cfg #(
	parameter int ANCHOR_COUNT = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [dbd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [dbd_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic [1:0]                   anchor_sel,
	output dbd_pkg::cfg_view_t           cfg
);
	import dbd_pkg::*;

	logic [12:0] score_min_q;
	logic [12:0] grid_step_q;
	logic [14:0] anchor_w_q [ANCHOR_COUNT];
	logic [14:0] anchor_h_q [ANCHOR_COUNT];
	logic [CFG_IDX_W-1:0] k;
	logic [1:0] sel;

	assign k = wr_index - REG_ANCHOR_BASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_min_q <= RST_SCORE_MIN;
			grid_step_q <= RST_GRID_STEP;
			for (int i = 0; i < ANCHOR_COUNT; i++) begin
				anchor_w_q[i] <= RST_ANCHOR;
				anchor_h_q[i] <= RST_ANCHOR;
			end
		end else if (wr_en) begin
			if (wr_index == REG_SCORE_MIN) begin
				score_min_q <= wr_data[12:0];
			end
			if (wr_index == REG_GRID_STEP) begin
				grid_step_q <= wr_data[12:0];
			end
			for (int i = 0; i < ANCHOR_COUNT; i++) begin
				if (wr_index >= REG_ANCHOR_BASE && k[2:1] == 2'(i)) begin
					if (k[0]) begin
						anchor_h_q[i] <= wr_data;
					end else begin
						anchor_w_q[i] <= wr_data;
					end
				end
			end
		end
	end

	// out of range anchor uses the last one
	assign sel = (anchor_sel >= 2'(ANCHOR_COUNT)) ? 2'(ANCHOR_COUNT - 1) : anchor_sel;

	always_comb begin
		cfg.score_min = score_min_q;
		cfg.grid_step = grid_step_q;
		cfg.anchor_w  = anchor_w_q[0];
		cfg.anchor_h  = anchor_h_q[0];
		for (int i = 0; i < ANCHOR_COUNT; i++) begin
			if (sel == 2'(i)) begin
				cfg.anchor_w = anchor_w_q[i];
				cfg.anchor_h = anchor_h_q[i];
			end
		end
	end

endmodule

### rtl/dbd_ctrl.sv
// controller of the detection box decoder: class accumulation and box decode sequencing
// depends on dbd_pkg
module dbd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output dbd_pkg::dbd_cmd_t  cmd
);
	import dbd_pkg::*;

	dbd_state_t state_q, state_d;
	logic run_open_q;
	logic out_valid_q;
	logic accept;
	logic out_free;

	assign accept   = in_valid && (state_q == ST_ACCUM);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACCUM: begin
				if (accept && in_last) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_BOUNDS;
			ST_BOUNDS: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_ACCUM;
				end
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != ST_ACCUM);
		cmd.sample   = accept && !run_open_q;
		cmd.accum    = accept;
		cmd.square   = (state_q == ST_SQUARE);
		cmd.scale    = (state_q == ST_SCALE);
		cmd.bounds   = (state_q == ST_BOUNDS);
		cmd.load_out = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			run_open_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				run_open_q <= !in_last;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/dbd_dp.sv
// datapath of the detection box decoder: best class tracking, box decode stages, result register
// depends on dbd_pkg
module dbd_dp #(
	parameter int MAX_CLASSES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dbd_pkg::dbd_cmd_t  cmd,
	input  dbd_pkg::in_item_t  in_data,
	input  dbd_pkg::cfg_view_t cfg,
	output logic [1:0]         anchor_sel,
	output dbd_pkg::out_item_t out_data
);
	import dbd_pkg::*;

	localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam logic [CW-1:0] CNT_LAST = CW'(MAX_CLASSES - 1);

	logic signed [15:0] raw_w_q, raw_h_q, raw_cx_q, raw_cy_q, obj_q;
	logic [7:0] col_q, row_q;
	logic [1:0] anchor_q;

	logic signed [15:0] best_score_q;
	logic [CW-1:0]      best_class_q;
	logic               have_best_q;
	logic [CW-1:0]      class_cnt_q;

	logic signed [16:0] th17, sc17, best17, obj17;
	logic               better;

	logic signed [31:0] sq_w_full, sq_h_full;
	logic [30:0]        sq_w_s1, sq_h_s1;
	logic [20:0]        off_x_s1, off_y_s1;

	logic [45:0]        prod_w, prod_h;
	logic signed [21:0] sum_x, sum_y;
	logic [14:0]        w_s2, h_s2;
	logic signed [15:0] cx_s2, cy_s2;

	logic signed [17:0] left_c, top_c;
	logic signed [17:0] left_s3, right_s3, top_s3, bot_s3;

	logic        off_box, keep;
	logic [12:0] cl, cr, ct, cb;
	logic [13:0] sum_lr, sum_tb;
	out_item_t   out_q;

	// best class above threshold, strictly greater replaces
	assign th17   = $signed({4'b0, cfg.score_min});
	assign sc17   = {in_data.class_score[15], in_data.class_score};
	assign best17 = {best_score_q[15], best_score_q};
	assign obj17  = {obj_q[15], obj_q};
	assign better = (sc17 > th17) && (!have_best_q || sc17 > best17);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_class_q <= '0;
			have_best_q  <= 1'b0;
			class_cnt_q  <= '0;
		end else if (cmd.load_out) begin
			best_score_q <= '0;
			best_class_q <= '0;
			have_best_q  <= 1'b0;
			class_cnt_q  <= '0;
		end else if (cmd.accum) begin
			if (better) begin
				best_score_q <= in_data.class_score;
				best_class_q <= class_cnt_q;
				have_best_q  <= 1'b1;
			end
			if (class_cnt_q != CNT_LAST) begin
				class_cnt_q <= class_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sample) begin
			raw_w_q  <= in_data.raw_w;
			raw_h_q  <= in_data.raw_h;
			raw_cx_q <= in_data.raw_cx;
			raw_cy_q <= in_data.raw_cy;
			obj_q    <= in_data.objectness;
			col_q    <= in_data.cell_col;
			row_q    <= in_data.cell_row;
			anchor_q <= in_data.anchor_index;
		end
	end

	assign anchor_sel = anchor_q;

	// square of raw size and cell offset
	assign sq_w_full = 32'(raw_w_q) * 32'(raw_w_q);
	assign sq_h_full = 32'(raw_h_q) * 32'(raw_h_q);

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sq_w_s1  <= sq_w_full[30:0];
			sq_h_s1  <= sq_h_full[30:0];
			off_x_s1 <= 21'(col_q) * 21'(cfg.grid_step);
			off_y_s1 <= 21'(row_q) * 21'(cfg.grid_step);
		end
	end

	// anchor scaling and centre
	assign prod_w = 46'(sq_w_s1) * 46'(cfg.anchor_w);
	assign prod_h = 46'(sq_h_s1) * 46'(cfg.anchor_h);
	assign sum_x  = {{6{raw_cx_q[15]}}, raw_cx_q} + $signed({1'b0, off_x_s1});
	assign sum_y  = {{6{raw_cy_q[15]}}, raw_cy_q} + $signed({1'b0, off_y_s1});

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			w_s2  <= (|prod_w[45:39]) ? SIZE_MAX : prod_w[38:24];
			h_s2  <= (|prod_h[45:39]) ? SIZE_MAX : prod_h[38:24];
			cx_s2 <= sat16(sum_x);
			cy_s2 <= sat16(sum_y);
		end
	end

	// box edges
	assign left_c = {{2{cx_s2[15]}}, cx_s2} - $signed({4'b0, w_s2[14:1]});
	assign top_c  = {{2{cy_s2[15]}}, cy_s2} - $signed({4'b0, h_s2[14:1]});

	always_ff @(posedge clk) begin
		if (cmd.bounds) begin
			left_s3  <= left_c;
			right_s3 <= left_c + $signed({3'b0, w_s2});
			top_s3   <= top_c;
			bot_s3   <= top_c + $signed({3'b0, h_s2});
		end
	end

	// cull and clip to the unit square
	always_comb begin
		off_box = (left_s3 >= Q_ONE_EDGE) || (right_s3 <= 18'sd0) ||
			(top_s3 >= Q_ONE_EDGE) || (bot_s3 <= 18'sd0);
		keep = (obj17 >= th17) && have_best_q && !off_box;
		cl = (left_s3 < 18'sd0) ? 13'd0 : left_s3[12:0];
		cr = (right_s3 > Q_ONE_EDGE) ? Q_ONE : right_s3[12:0];
		ct = (top_s3 < 18'sd0) ? 13'd0 : top_s3[12:0];
		cb = (bot_s3 > Q_ONE_EDGE) ? Q_ONE : bot_s3[12:0];
		sum_lr = 14'(cl) + 14'(cr);
		sum_tb = 14'(ct) + 14'(cb);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (keep) begin
				out_q.kept        <= 1'b1;
				out_q.probability <= best_score_q[14:0];
				out_q.label       <= 7'(best_class_q);
				out_q.center_x    <= sum_lr[13:1];
				out_q.center_y    <= sum_tb[13:1];
				out_q.width       <= cr - cl;
				out_q.height      <= cb - ct;
			end else begin
				out_q <= '0;
			end
		end
	end

	assign out_data = out_q;

endmodule

### rtl/detection_box_decode_top.sv
// Detection box decoder. A prediction arrives as a run of transactions, one per class score,
// the last one flagged by last_class; box fields, objectness, cell and anchor are taken from
// the first transaction of the run. Class transactions are accepted one per cycle. After the
// last one the input stalls while the shared box datapath squares the raw size, scales it
// by the anchor and adds the cell offset, forms the edges, then culls and clips the box
// into the result register. One result per run is held in the output register until
// taken; the next run may start while it waits, and its decode holds in the last step
// only if the previous result is still there. Configuration registers are written
// through cfg_wr_en / cfg_index / cfg_wr_data.
// depends on dbd_pkg, dbd_cfg, dbd_ctrl, dbd_dp
module detection_box_decode_top #(
	parameter int MAX_CLASSES  = 128,
	parameter int ANCHOR_COUNT = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [dbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  dbd_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output dbd_pkg::out_item_t             out_data
);
	import dbd_pkg::*;

	cfg_view_t  cfg;
	dbd_cmd_t   cmd;
	logic [1:0] anchor_sel;

	dbd_cfg #(
		.ANCHOR_COUNT(ANCHOR_COUNT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_wr_en),
		.wr_index  (cfg_index),
		.wr_data   (cfg_wr_data),
		.anchor_sel(anchor_sel),
		.cfg       (cfg)
	);

	dbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_data.last_class),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	dbd_dp #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg       (cfg),
		.anchor_sel(anchor_sel),
		.out_data  (out_data)
	);

endmodule

### tb/dbd_scoreboard_pkg.sv
// scoreboard for the detection box decoder testbench: predicts one result per class run
// and checks the results that come out against the predicted ones, oldest first
// depends on dbd_pkg
package dbd_scoreboard_pkg;
	import dbd_pkg::*;

	class box_scoreboard;
		logic [12:0] thresh;
		logic [12:0] cell_step;
		logic [14:0] anchor_wh [3][2];

		int         best_score;
		int         best_class;
		bit         have_best;
		int         class_cnt;
		bit         run_open;
		in_item_t   head;

		out_item_t  expected_q[$];
		int         errors;
		int         results_seen;
		int         kept_seen;

		function new();
			thresh = RST_SCORE_MIN;
			cell_step = RST_GRID_STEP;
			foreach (anchor_wh[i, j]) anchor_wh[i][j] = RST_ANCHOR;
			best_score = 0;
			best_class = 0;
			have_best = 0;
			class_cnt = 0;
			run_open = 0;
			head = '0;
			errors = 0;
			results_seen = 0;
			kept_seen = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			logic [CFG_IDX_W-1:0] k;
			if (idx == REG_SCORE_MIN) begin
				thresh = val[12:0];
			end else if (idx == REG_GRID_STEP) begin
				cell_step = val[12:0];
			end else begin
				k = idx - REG_ANCHOR_BASE;
				anchor_wh[k >> 1][k[0]] = val;
			end
		endfunction

		static function int clamp16(int v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return v;
		endfunction

		function int scaled_size(logic signed [15:0] raw, logic [14:0] anc);
			longint r;
			longint p;
			r = raw;
			p = (r * r * longint'(anc)) >>> 24;
			return (p > 32767) ? 32767 : int'(p);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_input(in_item_t it);
			int sc, th, a, w, h, cx, cy, lf, rt, tp, bt, cl, cr, ct, cb, mid, one;
			out_item_t e;
			if (!run_open) begin
				head = it;
				run_open = 1;
				class_cnt = 0;
			end
			th = int'(thresh);
			sc = $signed(it.class_score);
			if (sc > th && (!have_best || sc > best_score)) begin
				best_score = sc;
				best_class = class_cnt;
				have_best = 1;
			end
			if (class_cnt < 127) class_cnt++;
			if (!it.last_class) return;

			// out-of-range anchor falls back to the last one
			a = int'(head.anchor_index);
			if (a > 2) a = 2;
			w = scaled_size(head.raw_w, anchor_wh[a][0]);
			h = scaled_size(head.raw_h, anchor_wh[a][1]);
			cx = clamp16($signed(head.raw_cx) + int'(head.cell_col) * int'(cell_step));
			cy = clamp16($signed(head.raw_cy) + int'(head.cell_row) * int'(cell_step));
			lf = cx - (w >>> 1);
			rt = lf + w;
			tp = cy - (h >>> 1);
			bt = tp + h;
			one = int'(Q_ONE);
			e = '0;
			if ($signed(head.objectness) >= th && have_best &&
				!(lf >= one || rt <= 0 || tp >= one || bt <= 0)) begin
				cl = (lf < 0) ? 0 : lf;
				cr = (rt > one) ? one : rt;
				ct = (tp < 0) ? 0 : tp;
				cb = (bt > one) ? one : bt;
				e.kept = 1'b1;
				e.probability = best_score[14:0];
				e.label = best_class[6:0];
				mid = (cl + cr) >>> 1;
				e.center_x = mid[12:0];
				mid = (ct + cb) >>> 1;
				e.center_y = mid[12:0];
				mid = cr - cl;
				e.width = mid[12:0];
				mid = cb - ct;
				e.height = mid[12:0];
			end
			expected_q.push_back(e);
			best_score = 0;
			best_class = 0;
			have_best = 0;
			class_cnt = 0;
			run_open = 0;
		endfunction

		function void compare(string name, int exp_v, int got_v, realtime t);
			if (exp_v != got_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d actual %0d", t, name, exp_v, got_v);
			end
		endfunction

		function void check_result(out_item_t got, realtime t);
			out_item_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, kept %0d label %0d",
					t, got.kept, got.label);
				return;
			end
			e = expected_q.pop_front();
			results_seen++;
			if (got.kept) kept_seen++;
			compare("kept", int'(e.kept), int'(got.kept), t);
			compare("probability", int'(e.probability), int'(got.probability), t);
			compare("label", int'(e.label), int'(got.label), t);
			compare("center_x", int'(e.center_x), int'(got.center_x), t);
			compare("center_y", int'(e.center_y), int'(got.center_y), t);
			compare("width", int'(e.width), int'(got.width), t);
			compare("height", int'(e.height), int'(got.height), t);
		endfunction

		function void close(realtime t);
			if (expected_q.size() != 0) begin
				errors += expected_q.size();
				$display("%0t: %0d expected results never arrived", t, expected_q.size());
			end
		endfunction
	endclass

endpackage

### tb/detection_box_decode_top_test.sv
// testbench top for detection_box_decode_top: directed runs, then random class runs under
// several register settings, with random gaps on input and random output stalls
// depends on dbd_pkg, dbd_scoreboard_pkg and the decoder rtl
module detection_box_decode_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dbd_pkg::*;
	import dbd_scoreboard_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 160;
	localparam int N_PHASES    = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;

	box_scoreboard sb = new();
	bit quiet = 1'b0;
	int stall_left = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int settings_used = 1;

	detection_box_decode_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: check each transaction, stall in short and long bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_result(out_data, $realtime);
			if (cycle_count % 256 == 0) quiet <= ($urandom_range(0, 3) == 0);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (quiet || $urandom_range(0, 99) < 70) begin
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 9) < 8) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(9, 49);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic in_item_t mk(int w, int h, int cx, int cy, int obj, int sc,
		int col, int row, int anc, bit last);
		in_item_t it;
		it.raw_w = w[15:0];
		it.raw_h = h[15:0];
		it.raw_cx = cx[15:0];
		it.raw_cy = cy[15:0];
		it.objectness = obj[15:0];
		it.class_score = sc[15:0];
		it.cell_col = col[7:0];
		it.cell_row = row[7:0];
		it.anchor_index = anc[1:0];
		it.last_class = last;
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(it);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(int th, int cs, int anc[6]);
		write_reg(REG_SCORE_MIN, th[14:0]);
		write_reg(REG_GRID_STEP, cs[14:0]);
		for (int k = 0; k < 6; k++) begin
			write_reg(REG_ANCHOR_BASE + k[2:0], anc[k][14:0]);
		end
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// one prediction: shaped runs mostly land inside the unit square, the rest is noise
	task automatic send_run(int n, bit shaped, bit ramp);
		in_item_t head, it;
		logic [127:0] noise;
		int th, cs, cmax, col, row, v, s, prev_s, r;
		th = int'(sb.thresh);
		cs = int'(sb.cell_step);
		noise = {$urandom, $urandom, $urandom, $urandom};
		head = noise[$bits(in_item_t)-1:0];
		if (shaped) begin
			if ($urandom_range(0, 4) != 0) begin
				v = int'($urandom_range(0, 16384)) - 8192;
				head.raw_w = v[15:0];
				v = int'($urandom_range(0, 16384)) - 8192;
				head.raw_h = v[15:0];
			end
			cmax = (cs == 0) ? 255 : 4608 / cs;
			if (cmax > 255) cmax = 255;
			col = $urandom_range(0, cmax);
			row = $urandom_range(0, cmax);
			head.cell_col = col[7:0];
			head.cell_row = row[7:0];
			v = box_scoreboard::clamp16(int'($urandom_range(0, 6144)) - 1024 - col * cs);
			head.raw_cx = v[15:0];
			v = box_scoreboard::clamp16(int'($urandom_range(0, 6144)) - 1024 - row * cs);
			head.raw_cy = v[15:0];
			r = $urandom_range(0, 19);
			if (r < 16) begin
				v = th + int'($urandom_range(0, 32767 - th));
				head.objectness = v[15:0];
			end else if (r < 19) begin
				v = int'($urandom_range(0, th));
				head.objectness = v[15:0];
			end
			head.anchor_index = 2'($urandom_range(0, 3));
		end
		prev_s = th;
		for (int i = 0; i < n; i++) begin
			if (i == 0 || $urandom_range(0, 1) == 0) begin
				it = head;
			end else begin
				noise = {$urandom, $urandom, $urandom, $urandom};
				it = noise[$bits(in_item_t)-1:0];
			end
			r = $urandom_range(0, 9);
			if (ramp) begin
				s = th + 1 + i;
			end else if (shaped && r < 6) begin
				s = th - 300 + int'($urandom_range(0, 1500));
			end else if (shaped && r < 7) begin
				s = prev_s;
			end else begin
				s = int'(16'($urandom));
			end
			it.class_score = s[15:0];
			prev_s = s;
			it.last_class = (i == n - 1);
			send_item(it);
		end
	endtask

	initial begin
		int anc[6];
		int th, cs, n, start;
		bit shaped;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: culls, ties, thresholds, extremes, edges of the unit square
		send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		send_item(mk(4096, 4096, 2048, 2048, 2048, 2000, 0, 0, 0, 1));
		send_item(mk(4096, 2048, 1024, 1024, 4096, 2000, 4, 4, 1, 0));
		send_item(mk(4096, 2048, 1024, 1024, 4096, 2000, 4, 4, 1, 0));
		send_item(mk(4096, 2048, 1024, 1024, 4096, 1500, 4, 4, 1, 1));
		send_item(mk(3000, 5000, 500, 700, 4096, 1500, 8, 20, 2, 0));
		send_item(mk(3000, 5000, 500, 700, 4096, 3000, 8, 20, 2, 0));
		send_item(mk(3000, 5000, 500, 700, 4096, 3000, 8, 20, 2, 1));
		send_item(mk(4096, 4096, 2048, 2048, 4096, 1024, 0, 0, 0, 1));
		send_item(mk(4096, 4096, 2048, 2048, 1024, 32767, 0, 0, 3, 1));
		send_item(mk(32767, 32767, 32767, 32767, 32767, 32767, 255, 255, 3, 1));
		send_item(mk(-32768, -32768, -32768, -32768, -32768, -32768, 255, 255, 0, 1));
		send_item(mk(-32768, -8192, -32768, 100, 8192, 4096, 255, 0, 0, 1));
		send_item(mk(0, 0, 0, 0, 4096, 2000, 0, 0, 0, 1));
		send_item(mk(0, 0, 4096, 2048, 4096, 2000, 0, 0, 0, 1));
		send_item(mk(0, 0, 1000, 1000, 4096, 2000, 0, 0, 1, 1));
		send_item(mk(4096, 4096, 2048, 2048, 4096, -32768, 0, 0, 0, 1));
		send_item(mk(4096, 4096, 2048, 2048, 4096, 1500, 2, 3, 1, 0));
		send_item(mk(-1, -1, -1, -1, -1, 3000, 255, 255, 3, 1));
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			if (p == 1) begin
				foreach (anc[k]) anc[k] = 0;
				configure(0, 0, anc);
			end else if (p == 2) begin
				foreach (anc[k]) anc[k] = 32767;
				configure(4096, 4096, anc);
			end else if (p > 2) begin
				th = $urandom_range(0, 4096);
				cs = ($urandom_range(0, 1) == 0) ? $urandom_range(16, 256) :
					$urandom_range(0, 4096);
				foreach (anc[k]) begin
					anc[k] = ($urandom_range(0, 1) == 0) ? $urandom_range(1024, 12288) :
						$urandom_range(0, 32767);
				end
				configure(th, cs, anc);
			end
			start = items_sent;
			// more classes than labels: the last ones share the top label
			if (p == 3) send_run(133, 1'b1, 1'b1);
			while (items_sent - start < PHASE_ITEMS) begin
				shaped = ($urandom_range(0, 4) != 0);
				if (shaped && $urandom_range(0, 59) == 0) begin
					n = $urandom_range(120, 134);
				end else if (shaped) begin
					n = $urandom_range(1, 6);
				end else begin
					n = $urandom_range(1, 4);
				end
				send_run(n, shaped, 1'b0);
				if ($urandom_range(0, 49) == 0) drain();
			end
			drain();
		end

		sb.close($realtime);
		$display("sent %0d class transactions under %0d register settings",
			items_sent, settings_used);
		$display("checked %0d results, %0d kept, %0d errors",
			sb.results_seen, sb.kept_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
